### design/bmh_pkg.sv
// Shared types and constants for the binary max-heap core.
package bmh_pkg;

	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int TOTAL_W  = 7;

	// Operation codes carried on the request word
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	// Status codes carried on the response word
	localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POP_LOAD,
		ST_SIFT_UP,
		ST_SIFT_DOWN,
		ST_WRITEBACK,
		ST_DONE
	} state_t;

	typedef logic signed [VALUE_W-1:0] value_t;

endpackage

### design/bmh_ifs.sv
// Request and response stream interfaces of the heap core.
interface bmh_req_if import bmh_pkg::*;;
	logic   valid;
	logic   ready;
	logic   op;
	value_t value;

	modport source (output valid, output op, output value, input ready);
	modport sink (input valid, input op, input value, output ready);
endinterface

interface bmh_rsp_if import bmh_pkg::*;;
	logic                valid;
	logic                ready;
	value_t              popped_value;
	logic [STATUS_W-1:0] status;
	logic [TOTAL_W-1:0]  entry_total;

	modport source (output valid, output popped_value, output status, output entry_total,
		input ready);
	modport sink (input valid, input popped_value, input status, input entry_total,
		output ready);
endinterface

### design/bmh_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bmh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write on enable, register the read word every cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

### design/binary_max_heap_core.sv
// Push: IDLE, SIFT_UP while climbing, WRITEBACK, DONE; an empty heap skips SIFT_UP. Pop: IDLE,
// POP_LOAD, SIFT_DOWN while descending, WRITEBACK, DONE; the last entry: POP_LOAD, DONE. Empty
// pop or full push: IDLE, DONE. One level per cycle, set by the RAM read latency. A new word
// is accepted in the cycle after the response loads, also while that response waits.
// Two RAM copies hold the heap so both children of a node are read in the same cycle.
// Reset clears the entry count and the sequencer; heap RAM contents are not cleared.
module binary_max_heap_core import bmh_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	bmh_req_if.sink      req,
	bmh_rsp_if.source    rsp
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = AW + 2;

	state_t state_q, state_d;

	logic [CW-1:0]       count_q;
	logic [AW-1:0]       hole_q;
	value_t              val_q;
	value_t              res_value_q;
	logic [STATUS_W-1:0] res_status_q;

	logic                rsp_valid_q;
	value_t              rsp_value_q;
	logic [STATUS_W-1:0] rsp_status_q;
	logic [TOTAL_W-1:0]  rsp_total_q;

	logic                req_fire;
	logic                rsp_load;

	// RAM control
	logic                ram_wr_en;
	logic [AW-1:0]       ram_wr_addr;
	value_t              ram_wr_data;
	logic [AW-1:0]       rd_addr_a, rd_addr_b;
	logic                rd_issue;
	value_t              rd_a, rd_b;

	// Index arithmetic
	logic [AW-1:0]       parent_idx, grand_idx, push_parent;
	logic [XW-1:0]       count_ext, lc_hole, rc_hole, child_idx, lc_child, rc_child;
	logic                rc_ok, pick_right, lc_child_ok, push_full;
	logic [AW-1:0]       child_addr;
	value_t              child_val;

	assign req_fire = req.valid && req.ready;
	assign rsp_load = (state_q == ST_DONE) && (!rsp_valid_q || rsp.ready);
	assign push_full = (count_q == CW'(CAPACITY));

	// Parents for sift-up and for the first parent of a push
	assign parent_idx  = AW'((hole_q - AW'(1)) >> 1);
	assign grand_idx   = AW'((parent_idx - AW'(1)) >> 1);
	assign push_parent = AW'((count_q - CW'(1)) >> 1);

	// Children for sift-down: the larger one, left on a tie
	assign count_ext   = XW'(count_q);
	assign lc_hole     = {1'b0, hole_q, 1'b1};
	assign rc_hole     = lc_hole + XW'(1);
	assign rc_ok       = (rc_hole < count_ext);
	assign pick_right  = rc_ok && (rd_b > rd_a);
	assign child_idx   = pick_right ? rc_hole : lc_hole;
	assign child_val   = pick_right ? rd_b : rd_a;
	assign child_addr  = child_idx[AW-1:0];
	assign lc_child    = {1'b0, child_addr, 1'b1};
	assign rc_child    = lc_child + XW'(1);
	assign lc_child_ok = (lc_child < count_ext);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					if (req.op == OP_POP) begin
						state_d = (count_q == '0) ? ST_DONE : ST_POP_LOAD;
					end else if (push_full) begin
						state_d = ST_DONE;
					end else begin
						state_d = (count_q == '0) ? ST_WRITEBACK : ST_SIFT_UP;
					end
				end
			end
			ST_POP_LOAD: begin
				if (count_q == '0) begin
					state_d = ST_DONE;
				end else if (count_q == CW'(1)) begin
					state_d = ST_WRITEBACK;
				end else begin
					state_d = ST_SIFT_DOWN;
				end
			end
			ST_SIFT_UP: begin
				if (rd_a >= val_q || parent_idx == '0) begin
					state_d = ST_WRITEBACK;
				end
			end
			ST_SIFT_DOWN: begin
				if (!(child_val > val_q) || !lc_child_ok) begin
					state_d = ST_WRITEBACK;
				end
			end
			ST_WRITEBACK: state_d = ST_DONE;
			ST_DONE: begin
				if (rsp_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// RAM reads, writes and request ready
	always_comb begin
		req.ready   = (state_q == ST_IDLE);
		ram_wr_en   = 1'b0;
		ram_wr_addr = hole_q;
		ram_wr_data = val_q;
		rd_addr_a   = '0;
		rd_addr_b   = '0;
		rd_issue    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (req.op == OP_POP) begin
					rd_addr_a = '0;
					rd_addr_b = AW'(count_q - CW'(1));
				end else begin
					rd_addr_a = push_parent;
				end
				rd_issue = req_fire;
			end
			ST_POP_LOAD: begin
				rd_addr_a = AW'(1);
				rd_addr_b = AW'(2);
				rd_issue  = (count_q > CW'(1));
			end
			ST_SIFT_UP: begin
				if (rd_a < val_q) begin
					ram_wr_en   = 1'b1;
					ram_wr_data = rd_a;
					rd_addr_a   = grand_idx;
					rd_issue    = (parent_idx != '0);
				end
			end
			ST_SIFT_DOWN: begin
				if (child_val > val_q) begin
					ram_wr_en   = 1'b1;
					ram_wr_data = child_val;
					rd_addr_a   = lc_child[AW-1:0];
					rd_addr_b   = rc_child[AW-1:0];
					rd_issue    = lc_child_ok;
				end
			end
			ST_WRITEBACK: ram_wr_en = 1'b1;
			ST_DONE: ;
			default: ;
		endcase
	end

	// Two copies of the heap, written together
	bmh_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_ram_a (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_addr (rd_addr_a),
		.rd_data (rd_a)
	);

	bmh_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_ram_b (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_addr (rd_addr_b),
		.rd_data (rd_b)
	);

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (req_fire) begin
				if (req.op == OP_POP && count_q != '0) begin
					count_q <= count_q - CW'(1);
				end else if (req.op == OP_PUSH && !push_full) begin
					count_q <= count_q + CW'(1);
				end
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Hole index, sifted value and response word
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				res_value_q <= '0;
				val_q       <= req.value;
				hole_q      <= AW'(count_q);
				if (req.op == OP_POP && count_q == '0) begin
					res_status_q <= STATUS_EMPTY;
				end else if (req.op == OP_PUSH && push_full) begin
					res_status_q <= STATUS_FULL;
				end else begin
					res_status_q <= STATUS_DONE;
				end
			end
			ST_POP_LOAD: begin
				res_value_q <= rd_a;
				val_q       <= rd_b;
				hole_q      <= '0;
			end
			ST_SIFT_UP: begin
				if (rd_a < val_q) begin
					hole_q <= parent_idx;
				end
			end
			ST_SIFT_DOWN: begin
				if (child_val > val_q) begin
					hole_q <= child_addr;
				end
			end
			default: ;
		endcase
		if (rsp_load) begin
			rsp_value_q  <= res_value_q;
			rsp_status_q <= res_status_q;
			rsp_total_q  <= TOTAL_W'(count_q);
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.popped_value = rsp_value_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.entry_total  = rsp_total_q;

	// A read never targets the entry written in the same cycle
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_wr_en && rd_issue) |-> (ram_wr_addr != rd_addr_a && ram_wr_addr != rd_addr_b))
		else $error("heap read and write hit the same entry");

	// Entry count stays within capacity
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	// An accepted word always starts work
	a_fire_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> (state_q != ST_IDLE))
		else $error("accepted word did not start work");

	// A finished word waits while the response slot is full
	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && rsp_valid_q && !rsp.ready) |=> (state_q == ST_DONE))
		else $error("response slot overwritten");

	// An empty-pop response reports an empty heap
	a_empty_total: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_load && res_status_q == STATUS_EMPTY) |-> (count_q == '0))
		else $error("empty pop with entries held");

endmodule
